// ----- rtl/core/smf_pkg.sv -----
`timescale 1ns / 1ps
package smf_pkg;

	// Window and sample geometry.
	localparam int MAX_WINDOW  = 15;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_RADIUS  = (MAX_WINDOW - 1) / 2;
	localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
	localparam int RAD_W       = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS + 1) : 1;

	// The window size register is four bits wide and resets to three.
	localparam int               CFG_W     = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

	// Queue depths between the sides.
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [MAX_WINDOW-1:0] win_t;

	// Input request payload.
	typedef struct packed {
		sample_t sample;
		logic    last_in;
	} smf_in_t;

	// Result payload.
	typedef struct packed {
		sample_t median;
		logic    last_out;
	} smf_out_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		sample_t sample;
		logic    last;
		logic    first;
	} smf_cmd_t;

	// Effective window: clamped to the store size, at least one, rounded down to odd.
	function automatic logic [WIN_W-1:0] smf_eff_window(input logic [CFG_W-1:0] ws);
		logic [WIN_W-1:0] w;
		if (int'(ws) > MAX_WINDOW) begin
			w = WIN_W'(MAX_WINDOW);
		end else begin
			w = WIN_W'(ws);
		end
		if (w == '0) begin
			w = WIN_W'(1);
		end
		if (w[0] == 1'b0) begin
			w = w - 1'b1;
		end
		return w;
	endfunction

endpackage

// ----- rtl/core/smf_front.sv -----
`timescale 1ns / 1ps
module smf_front import smf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  smf_in_t  in_data,
	output logic     full,
	output logic     cmd_valid,
	output smf_cmd_t cmd,
	input  logic     cmd_pop
);

	smf_cmd_t             mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]   wr_q;
	logic [CMDQ_AW-1:0]   rd_q;
	logic [CMDQ_CW-1:0]   cnt_q;
	logic                 in_frame_q;
	logic                 do_push;
	logic                 do_pop;
	smf_cmd_t             new_cmd;

	// Queue status and handshake.
	assign full      = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_q];

	// A request that arrives outside a frame opens a new one.
	always_comb begin
		new_cmd.sample = in_data.sample;
		new_cmd.last   = in_data.last_in;
		new_cmd.first  = !in_frame_q;
	end

	// Frame tracking and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			wr_q       <= '0;
			rd_q       <= '0;
			cnt_q      <= '0;
		end else begin
			if (do_push) begin
				in_frame_q <= !in_data.last_in;
				wr_q       <= (wr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= new_cmd;
		end
	end

endmodule

// ----- rtl/core/smf_median.sv -----
`timescale 1ns / 1ps
module smf_median import smf_pkg::*; (
	input  logic                   clk,
	input  logic                   capture,
	input  win_t                   win,
	input  logic [MAX_WINDOW-1:0]  act,
	input  logic [RAD_W-1:0]       rank,
	output sample_t                median
);

	win_t                  val_s1;
	logic [MAX_WINDOW-1:0] prec_s1 [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] act_s1;
	logic [RAD_W-1:0]      rank_s1;

	// Compare every pair of active entries; ties are broken by position so ranks are unique.
	always_ff @(posedge clk) begin
		if (capture) begin
			val_s1  <= win;
			act_s1  <= act;
			rank_s1 <= rank;
			for (int i = 0; i < MAX_WINDOW; i++) begin
				for (int j = 0; j < MAX_WINDOW; j++) begin
					prec_s1[i][j] <= act[j] &&
						(($signed(win[j]) < $signed(win[i])) ||
						 ((win[j] == win[i]) && (j < i)));
				end
			end
		end
	end

	// The active entry with exactly rank entries ahead of it is the median.
	always_comb begin
		median = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (act_s1[i] && ($countones(prec_s1[i]) == int'(rank_s1))) begin
				median = val_s1[i];
			end
		end
	end

endmodule

// ----- rtl/core/smf_back.sv -----
`timescale 1ns / 1ps
module smf_back import smf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] win_len,
	input  logic             cmd_valid,
	input  smf_cmd_t         cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output smf_out_t         out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_CMP,
		ST_SEL
	} state_t;

	state_t                state_q;
	smf_cmd_t              cur_q;
	logic [RAD_W-1:0]      left_q;
	logic [RAD_W-1:0]      fill_q;
	logic                  final_q;
	win_t                  win_q;

	smf_out_t              outq_mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]    outq_wr_q;
	logic [OUTQ_AW-1:0]    outq_rd_q;
	logic [OUTQ_CW-1:0]    outq_cnt_q;

	logic [WIN_W-1:0]      w;
	logic [RAD_W-1:0]      r;
	logic [MAX_WINDOW-1:0] act;
	logic                  step_en;
	logic                  step_fill;
	logic                  step_last;
	sample_t               step_x;
	logic [RAD_W-1:0]      fill_base;
	logic [RAD_W-1:0]      left_after;
	logic                  step_emit;
	logic                  out_room;
	logic                  push_out;
	logic                  pop_out;
	sample_t               median;
	smf_out_t              new_out;

	// Window geometry from the register.
	always_comb begin
		w = smf_eff_window(win_len);
		r = RAD_W'(w >> 1);
		for (int k = 0; k < MAX_WINDOW; k++) begin
			act[k] = ((k + int'(w)) >= MAX_WINDOW);
		end
	end

	// One window step: either a new request or one flush step of the held last sample.
	always_comb begin
		cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
		step_en    = cmd_pop || (state_q == ST_FLUSH);
		step_x     = cmd_pop ? cmd.sample : cur_q.sample;
		step_fill  = cmd_pop && cmd.first;
		step_last  = cmd_pop ? cmd.last : cur_q.last;
		fill_base  = step_fill ? '0 : fill_q;
		left_after = cmd_pop ? (cmd.last ? r : '0) : (left_q - 1'b1);
		step_emit  = (fill_base >= r);
	end

	// Result queue status.
	assign out_room = (outq_cnt_q != OUTQ_CW'(OUTQ_DEPTH));
	assign push_out = (state_q == ST_SEL) && out_room;
	assign empty    = (outq_cnt_q == '0);
	assign pop_out  = pop && !empty;
	assign out_data = outq_mem_q[outq_rd_q];

	always_comb begin
		new_out.median   = median;
		new_out.last_out = final_q;
	end

	// Sequencer: step the window and, when a median is due, compare, then select and queue it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			left_q  <= '0;
			fill_q  <= '0;
			final_q <= 1'b0;
		end else begin
			unique case (state_q) inside
				ST_IDLE, ST_FLUSH: begin
					if (step_en) begin
						if (cmd_pop) begin
							cur_q <= cmd;
						end
						left_q  <= left_after;
						final_q <= step_last && (left_after == '0);
						if (step_emit) begin
							fill_q  <= fill_base;
							state_q <= ST_CMP;
						end else if (left_after != '0) begin
							fill_q  <= fill_base + 1'b1;
							state_q <= ST_FLUSH;
						end else begin
							fill_q  <= step_last ? '0 : fill_base + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CMP: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (out_room) begin
						if (left_q != '0) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_IDLE;
							if (cur_q.last) begin
								fill_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window store: newest sample at the top; a frame start fills every entry.
	always_ff @(posedge clk) begin
		if (step_en) begin
			for (int k = 0; k < MAX_WINDOW - 1; k++) begin
				win_q[k] <= step_fill ? step_x : win_q[k + 1];
			end
			win_q[MAX_WINDOW - 1] <= step_x;
		end
	end

	// Median unit works on a snapshot of the store.
	smf_median u_median (
		.clk     (clk),
		.capture (state_q == ST_CMP),
		.win     (win_q),
		.act     (act),
		.rank    (r),
		.median  (median)
	);

	// Result queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outq_wr_q  <= '0;
			outq_rd_q  <= '0;
			outq_cnt_q <= '0;
		end else begin
			if (push_out) begin
				outq_wr_q <= (outq_wr_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : outq_wr_q + 1'b1;
			end
			if (pop_out) begin
				outq_rd_q <= (outq_rd_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : outq_rd_q + 1'b1;
			end
			if (push_out && !pop_out) begin
				outq_cnt_q <= outq_cnt_q + 1'b1;
			end else if (!push_out && pop_out) begin
				outq_cnt_q <= outq_cnt_q - 1'b1;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push_out) begin
			outq_mem_q[outq_wr_q] <= new_out;
		end
	end

endmodule

// ----- rtl/core/sliding_median_filter_top.sv -----
`timescale 1ns / 1ps
// With the back end idle, a request passes the command queue, a window step, ST_CMP
// and ST_SEL before its median can be popped. A request that yields a median runs
// through ST_CMP and ST_SEL, one that only fills the window does not; a last request adds
// one flush step per unit of radius, each with ST_CMP and ST_SEL when it yields a median.
// Reset (arst_n low, asynchronous) empties both queues, ends any frame, sets the window to 3.
module sliding_median_filter_top import smf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  smf_in_t          in_data,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output smf_out_t         out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0] win_len_q;
	logic             cmd_valid;
	logic             cmd_pop;
	smf_cmd_t         cmd;

	// Window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= CFG_RESET;
		end else if (cfg_we) begin
			win_len_q <= cfg_wdata;
		end
	end

	smf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_data   (in_data),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	smf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.win_len     (win_len_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.out_data    (out_data)
	);

endmodule
